/* rtl/core/lis_pkg.sv */
package lis_pkg;

  // Field widths of the channels.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned NodeIdxW = 3;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned ValW    = 48;
  localparam int unsigned StAddrW = 14;
  localparam int unsigned ElemW   = 6;
  localparam int unsigned CompW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 4;

  // Item function codes.
  localparam logic [FuncW-1:0] FN_LOAD_NODE = 2'd0;
  localparam logic [FuncW-1:0] FN_LOAD_VAL  = 2'd1;
  localparam logic [FuncW-1:0] FN_EVAL      = 2'd2;
  localparam logic [FuncW-1:0] FN_NONE      = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_NODES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMPS = 2'd1;

  // Saturation bounds of a 48-bit signed value.
  localparam logic signed [ValW-1:0] VAL_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ValW-1:0] VAL_NEG = 48'sh8000_0000_0000;

  // Request and response of the shared multiplier.
  typedef struct packed {
    logic                   start;
    logic signed [ValW-1:0] a;
    logic signed [ValW-1:0] b;
    logic                   sh32;
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ValW-1:0] res;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_PART,
    MS_RND,
    MS_SAT
  } mul_st_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE1,
    S_BASE2,
    S_B_INIT,
    S_B_CHK,
    S_B_WP,
    S_B_WW,
    S_M_RD,
    S_M_T1,
    S_M_W1,
    S_M_W2,
    S_OUT
  } seq_st_e;

endpackage

/* rtl/core/lis_if.sv */
interface lis_in_if import lis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FuncW-1:0]           func;
  logic [NodeIdxW-1:0]        node_index;
  logic signed [CoordW-1:0]   node_position;
  logic signed [ValW-1:0]     basis_weight;
  logic [StAddrW-1:0]         store_address;
  logic signed [ValW-1:0]     nodal_value;
  logic [ElemW-1:0]           element;
  logic signed [CoordW-1:0]   ref_x;
  logic signed [CoordW-1:0]   ref_y;

  modport source (output valid, func, node_index, node_position, basis_weight,
                  store_address, nodal_value, element, ref_x, ref_y,
                  input ready);
  modport sink (input valid, func, node_index, node_position, basis_weight,
                store_address, nodal_value, element, ref_x, ref_y,
                output ready);
endinterface

interface lis_out_if import lis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] interpolated_value;
  logic [CompW-1:0]       component;
  logic                   last_of_run;

  modport source (output valid, interpolated_value, component, last_of_run,
                  input ready);
  modport sink (input valid, interpolated_value, component, last_of_run,
                output ready);
endinterface

interface lis_cfg_if import lis_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/lis_mul.sv */
module lis_mul import lis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned HalfW = ValW / 2;
  localparam int unsigned ProdW = 2 * ValW;
  localparam int unsigned RsW   = ProdW + 1 - 30;

  mul_st_e st_q, st_d;
  logic [1:0]          k_q, k_d;
  logic [ValW-1:0]     ua_q, ua_d, ub_q, ub_d;
  logic                neg_q, neg_d, sh32_q, sh32_d;
  logic [ProdW-1:0]    acc_q, acc_d;
  logic [RsW-1:0]      rs_q, rs_d;
  logic                done_q, done_d;
  logic signed [ValW-1:0] res_q, res_d;

  logic [HalfW-1:0]    a_half, b_half;
  logic [ValW-1:0]     pp;
  logic [6:0]          pp_sh;
  logic [ProdW:0]      rnd_sum;
  logic [ValW-1:0]     lim, mag;

  // Partial product of the current 24-bit halves, the rounding add and the saturation limit.
  always_comb begin
    a_half  = k_q[1] ? ua_q[ValW-1:HalfW] : ua_q[HalfW-1:0];
    b_half  = k_q[0] ? ub_q[ValW-1:HalfW] : ub_q[HalfW-1:0];
    pp      = a_half * b_half;
    pp_sh   = (k_q[1] ? 7'(HalfW) : 7'd0) + (k_q[0] ? 7'(HalfW) : 7'd0);
    rnd_sum = {1'b0, acc_q} + (sh32_q ? ((ProdW+1)'(1) << 31)
                                      : ((ProdW+1)'(1) << 29));
    lim     = neg_q ? VAL_NEG : VAL_POS;
    mag     = (rs_q > RsW'(lim)) ? lim : rs_q[ValW-1:0];
  end

  // Operation sequencing: load, four partial products, round, saturate.
  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    ua_d   = ua_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    sh32_d = sh32_q;
    acc_d  = acc_q;
    rs_d   = rs_q;
    done_d = 1'b0;
    res_d  = res_q;
    case (st_q)
      MS_IDLE: begin
        if (req_i.start) begin
          ua_d   = req_i.a[ValW-1] ? ValW'(-req_i.a) : ValW'(req_i.a);
          ub_d   = req_i.b[ValW-1] ? ValW'(-req_i.b) : ValW'(req_i.b);
          neg_d  = req_i.a[ValW-1] ^ req_i.b[ValW-1];
          sh32_d = req_i.sh32;
          acc_d  = '0;
          k_d    = 2'd0;
          st_d   = MS_PART;
        end
      end
      MS_PART: begin
        acc_d = acc_q + (ProdW'(pp) << pp_sh);
        k_d   = k_q + 2'd1;
        if (k_q == 2'd3) begin
          st_d = MS_RND;
        end
      end
      MS_RND: begin
        rs_d = sh32_q ? RsW'(rnd_sum >> 32) : RsW'(rnd_sum >> 30);
        st_d = MS_SAT;
      end
      MS_SAT: begin
        res_d  = neg_q ? -$signed(mag) : $signed(mag);
        done_d = 1'b1;
        st_d   = MS_IDLE;
      end
      default: st_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MS_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    neg_q  <= neg_d;
    sh32_q <= sh32_d;
    acc_q  <= acc_d;
    rs_q   <= rs_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* rtl/core/lis_mem.sv */
module lis_mem import lis_pkg::*; #(
  parameter int unsigned Depth = 12288,
  parameter int unsigned IdxW  = 14
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic signed [ValW-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  output logic signed [ValW-1:0] rd_data_o
);

  logic signed [ValW-1:0] mem_q [Depth];

  // Single write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_idx_i];
    end
  end

endmodule

/* rtl/core/lagrange_interp_2d.sv */
// Channel | Dir | Handshake   | Payload
// in_i    | in  | valid/ready | func, node and weight, store write, point to evaluate
// res_o   | out | valid/ready | interpolated_value, component, last_of_run
// cfg_i   | in  | valid/ready | register index, write data (always ready)
//
// Load items (func 0 and 1) finish in the cycle they are accepted.
// A point's evaluation is paced by the single shared multiplier, which forms
// each 48x48 product from four 24x24 passes.
// in_i.ready is high only while the sequencer is idle.
// Reset is asynchronous and active low; stores are not cleared.
// A stalled result holds the sequencer in its output step.
module lagrange_interp_2d import lis_pkg::*; #(
  parameter int unsigned MAX_NODES      = 8,
  parameter int unsigned MAX_ELEMS      = 64,
  parameter int unsigned MAX_COMPONENTS = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source res_o,
  lis_cfg_if.sink   cfg_i
);

  localparam int unsigned Depth = MAX_ELEMS * MAX_COMPONENTS * MAX_NODES * MAX_NODES;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned AddrW = $clog2(64 * MAX_NODES * MAX_NODES * MAX_COMPONENTS + 1);
  localparam int unsigned KW    = $clog2(MAX_NODES);
  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned CW    = $clog2(MAX_COMPONENTS + 1);
  localparam int unsigned SumW  = ValW + $clog2(MAX_NODES * MAX_NODES) + 1;

  seq_st_e st_q, st_d;
  logic [CfgDatW-1:0] cfg_n_q, cfg_c_q;
  logic [NW-1:0]      n_q, n_d, i_q, i_d, j_q, j_d, jx_q, jx_d, ky_q, ky_d;
  logic [CW-1:0]      nc_q, nc_d, f_q, f_d;
  logic [ElemW-1:0]   el_q, el_d;
  logic signed [CoordW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic               coord_q, coord_d;
  logic signed [ValW-1:0] p_q, p_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic               oob_q;
  logic               ov_q, ov_d, olast_q, olast_d;
  logic signed [ValW-1:0] oval_q, oval_d;
  logic [CompW-1:0]   ocomp_q, ocomp_d;

  logic signed [CoordW-1:0] node_q   [MAX_NODES];
  logic signed [ValW-1:0]   weight_q [MAX_NODES];
  logic signed [ValW-1:0]   xb_q     [MAX_NODES];
  logic signed [ValW-1:0]   yb_q     [MAX_NODES];

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     in_acc, mem_wr, mem_rd, basis_wr;
  logic signed [ValW-1:0] mem_rdata, mem_v;
  logic [NW-1:0]      n_eff;
  logic [CW-1:0]      nc_eff;
  logic signed [CoordW:0] diff;
  logic signed [CoordW-1:0] coord;
  logic [2*NW-1:0]    nn;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Effective node and component counts, clamped into range.
  always_comb begin
    if (cfg_n_q < CfgDatW'(2)) begin
      n_eff = NW'(2);
    end else if (int'(cfg_n_q) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(cfg_n_q);
    end
    if (cfg_c_q == '0) begin
      nc_eff = CW'(1);
    end else if (int'(cfg_c_q) > MAX_COMPONENTS) begin
      nc_eff = CW'(MAX_COMPONENTS);
    end else begin
      nc_eff = CW'(cfg_c_q);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q <= CfgDatW'(2);
      cfg_c_q <= CfgDatW'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == CFG_NODES) begin
        cfg_n_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_COMPS) begin
        cfg_c_q <= CfgDatW'(cfg_i.data[1:0]);
      end
    end
  end

  // Node and weight stores.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.func == FN_LOAD_NODE && int'(in_i.node_index) < MAX_NODES) begin
      node_q[KW'(in_i.node_index)]   <= in_i.node_position;
      weight_q[KW'(in_i.node_index)] <= in_i.basis_weight;
    end
    if (basis_wr) begin
      if (coord_q) begin
        yb_q[KW'(i_q)] <= mrsp.res;
      end else begin
        xb_q[KW'(i_q)] <= mrsp.res;
      end
    end
  end

  // Nodal value store.
  assign mem_wr = in_acc && in_i.func == FN_LOAD_VAL && int'(in_i.store_address) < Depth;

  lis_mem #(.Depth(Depth), .IdxW(IdxW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_idx_i  (IdxW'(in_i.store_address)),
    .wr_data_i (in_i.nodal_value),
    .rd_en_i   (mem_rd),
    .rd_idx_i  (IdxW'(addr_q)),
    .rd_data_o (mem_rdata)
  );

  lis_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign coord = coord_q ? ry_q : rx_q;
  assign diff  = {coord[CoordW-1], coord} - {node_q[KW'(j_q)][CoordW-1], node_q[KW'(j_q)]};
  assign nn    = n_q * n_q;
  assign mem_v = oob_q ? '0 : mem_rdata;

  // Sequencer: basis products, then multiply-accumulate per component.
  always_comb begin
    st_d     = st_q;
    n_d      = n_q;
    nc_d     = nc_q;
    el_d     = el_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    coord_d  = coord_q;
    i_d      = i_q;
    j_d      = j_q;
    jx_d     = jx_q;
    ky_d     = ky_q;
    f_d      = f_q;
    p_d      = p_q;
    addr_d   = addr_q;
    sum_d    = sum_q;
    ov_d     = ov_q && !res_o.ready;
    oval_d   = oval_q;
    ocomp_d  = ocomp_q;
    olast_d  = olast_q;
    mreq     = '0;
    mem_rd   = 1'b0;
    basis_wr = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_acc && in_i.func == FN_EVAL) begin
          n_d     = n_eff;
          nc_d    = nc_eff;
          el_d    = in_i.element;
          rx_d    = in_i.ref_x;
          ry_d    = in_i.ref_y;
          coord_d = 1'b0;
          i_d     = '0;
          st_d    = S_BASE1;
        end
      end
      S_BASE1: begin
        addr_d = AddrW'(el_q) * AddrW'(nn);
        st_d   = S_BASE2;
      end
      S_BASE2: begin
        addr_d = AddrW'(addr_q * nc_q);
        st_d   = S_B_INIT;
      end
      S_B_INIT: begin
        p_d  = ValW'(1) << (6'(n_q) + 6'd29);
        j_d  = '0;
        st_d = S_B_CHK;
      end
      S_B_CHK: begin
        if (j_q == n_q) begin
          mreq.start = 1'b1;
          mreq.a     = weight_q[KW'(i_q)];
          mreq.b     = p_q;
          st_d       = S_B_WW;
        end else if (j_q == i_q) begin
          j_d = j_q + NW'(1);
        end else begin
          mreq.start = 1'b1;
          mreq.a     = p_q;
          mreq.b     = ValW'(diff);
          st_d       = S_B_WP;
        end
      end
      S_B_WP: begin
        if (mrsp.done) begin
          p_d  = mrsp.res;
          j_d  = j_q + NW'(1);
          st_d = S_B_CHK;
        end
      end
      S_B_WW: begin
        if (mrsp.done) begin
          basis_wr = 1'b1;
          if (i_q == n_q - NW'(1)) begin
            i_d = '0;
            if (coord_q) begin
              f_d   = '0;
              jx_d  = '0;
              ky_d  = '0;
              sum_d = '0;
              st_d  = S_M_RD;
            end else begin
              coord_d = 1'b1;
              st_d    = S_B_INIT;
            end
          end else begin
            i_d  = i_q + NW'(1);
            st_d = S_B_INIT;
          end
        end
      end
      S_M_RD: begin
        mem_rd = 1'b1;
        st_d   = S_M_T1;
      end
      S_M_T1: begin
        mreq.start = 1'b1;
        mreq.a     = mem_v;
        mreq.b     = yb_q[KW'(ky_q)];
        mreq.sh32  = 1'b1;
        st_d       = S_M_W1;
      end
      S_M_W1: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = mrsp.res;
          mreq.b     = xb_q[KW'(jx_q)];
          mreq.sh32  = 1'b1;
          st_d       = S_M_W2;
        end
      end
      S_M_W2: begin
        if (mrsp.done) begin
          sum_d  = sum_q + SumW'(mrsp.res);
          addr_d = addr_q + AddrW'(1);
          st_d   = S_M_RD;
          if (jx_q == n_q - NW'(1)) begin
            jx_d = '0;
            if (ky_q == n_q - NW'(1)) begin
              ky_d = '0;
              st_d = S_OUT;
            end else begin
              ky_d = ky_q + NW'(1);
            end
          end else begin
            jx_d = jx_q + NW'(1);
          end
        end
      end
      S_OUT: begin
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          ocomp_d = CompW'(f_q);
          olast_d = (f_q == nc_q - CW'(1));
          if (sum_q > SumW'(VAL_POS)) begin
            oval_d = VAL_POS;
          end else if (sum_q < SumW'(VAL_NEG)) begin
            oval_d = VAL_NEG;
          end else begin
            oval_d = ValW'(sum_q);
          end
          if (f_q == nc_q - CW'(1)) begin
            st_d = S_IDLE;
          end else begin
            f_d   = f_q + CW'(1);
            sum_d = '0;
            st_d  = S_M_RD;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    nc_q    <= nc_d;
    el_q    <= el_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    coord_q <= coord_d;
    i_q     <= i_d;
    j_q     <= j_d;
    jx_q    <= jx_d;
    ky_q    <= ky_d;
    f_q     <= f_d;
    p_q     <= p_d;
    addr_q  <= addr_d;
    sum_q   <= sum_d;
    oval_q  <= oval_d;
    ocomp_q <= ocomp_d;
    olast_q <= olast_d;
    if (mem_rd) begin
      oob_q <= !(int'(addr_q) < Depth);
    end
  end

  assign res_o.valid              = ov_q;
  assign res_o.interpolated_value = oval_q;
  assign res_o.component          = ocomp_q;
  assign res_o.last_of_run        = olast_q;

endmodule

/* rtl/core/lis_chk.sv */
module lis_chk import lis_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [FuncW-1:0]       in_func,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [ValW-1:0] out_value,
  input logic                   out_last
);

  // An accepted point blocks the input channel in the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_func == FN_EVAL) |=> !in_ready)
    else $error("input ready after point transaction");

  // A load transaction never produces a new result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_func != FN_EVAL) |=> !$rose(out_valid))
    else $error("result after load transaction");

  // Once the last result of a point is taken, nothing follows at once.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result right after last of point");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed");

endmodule

bind lagrange_interp_2d lis_chk u_lis_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_func   (in_i.func),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_value (res_o.interpolated_value),
  .out_last  (res_o.last_of_run)
);
